// File: rtl/core/sine_tone_generator_macros.svh
`ifndef SINE_TONE_GENERATOR_MACROS_SVH
`define SINE_TONE_GENERATOR_MACROS_SVH

// implication checked in the same cycle, ignored during reset
`define STE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sine tone generator: same-cycle check failed");

// implication checked in the next cycle, ignored during reset
`define STE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sine tone generator: next-cycle check failed");

// property checked at every edge, reset included
`define STE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("sine tone generator: invariant failed");

`endif

// File: rtl/core/ste_pkg.sv
package ste_pkg;

  localparam int unsigned STE_CFG_IDX_W  = 2;
  localparam int unsigned STE_CFG_DATA_W = 32;

  typedef enum logic [STE_CFG_IDX_W-1:0] {
    CFG_PHASE_INC  = 2'd0,
    CFG_OUT_FORMAT = 2'd1,
    CFG_CHAN_COUNT = 2'd2,
    CFG_TONE_LEN   = 2'd3
  } ste_cfg_idx_e;

  localparam logic [30:0] PHASE_INC_RESET = 31'd10713070;
  localparam logic        FORMAT_RESET    = 1'b0;
  localparam logic [1:0]  CHAN_CNT_RESET  = 2'd1;
  localparam logic [31:0] TONE_LEN_RESET  = 32'd44100;

  // floor(w / 257) == (w * 65281) >> 24 for any 16-bit w
  localparam logic [15:0] U8_RECIP    = 16'd65281;
  localparam logic [16:0] SINE_OFFSET = 17'd65535;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [30:0] phase_inc;
    logic        out_format;
    logic [1:0]  chan_count;
    logic [31:0] tone_len;
  } ste_cfg_t;

  typedef struct packed {
    logic [15:0] mag;
    logic        neg;
    logic        done;
  } ste_entry_t;

endpackage

// File: rtl/core/sine_tone_generator_if.sv
interface sine_tone_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface sine_tone_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic        channel;
  logic        last_in_frame;
  logic        tone_done;

  modport source (output valid, output sample, output channel, output last_in_frame,
                  output tone_done, input ready);
  modport sink (input valid, input sample, input channel, input last_in_frame,
                input tone_done, output ready);
endinterface

// File: rtl/core/ste_front.sv
module ste_front #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ste_pkg::ste_cfg_t   cfg_i,
  sine_tone_in_if.sink        in_i,
  output ste_pkg::ste_entry_t entry_o,
  output logic                entry_valid_o,
  input  logic                entry_ready_i
);
  import ste_pkg::*;

  localparam int unsigned TableSize = 2 ** TABLE_ADDR_BITS;

  typedef logic [15:0] rom_t [TableSize];
  typedef logic [31:0] coef_t [7];

  // q30 taylor coefficients of sin(pi/2 * t), magnitudes
  localparam coef_t SineCoef = '{
    32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995,
    32'd172272, 32'd3864, 32'd61
  };

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] e;
    for (int k = 0; k < TableSize; k++) begin
      t = 64'(2 * k + 1) << (29 - TABLE_ADDR_BITS);
      u = (t * t) >> 30;
      r = 64'(SineCoef[6]);
      for (int i = 5; i >= 0; i--) begin
        p = (r * u) >> 30;
        r = (p >= 64'(SineCoef[i])) ? 64'd0 : 64'(SineCoef[i]) - p;
      end
      s = (r * t) >> 30;
      e = (s * 64'd65535 + (64'd1 << 29)) >> 30;
      if (e > 64'd65535) begin
        e = 64'd65535;
      end
      rom[k] = e[15:0];
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [PHASE_BITS-1:0]      phase_q, phase_d;
  logic [31:0]                frame_q, frame_d;
  logic                       s1_valid_q, s1_valid_d;
  logic [15:0]                rom_q;
  logic                       neg_q;
  logic                       done_q;

  logic                       accept;
  logic [PHASE_BITS-1:0]      ph;
  logic [31:0]                fi;
  logic                       done;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] addr;

  assign in_i.ready = !s1_valid_q || entry_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    ph   = in_i.restart ? '0 : phase_q;
    fi   = in_i.restart ? '0 : frame_q;
    done = ({1'b0, fi} + 33'd1) >= {1'b0, cfg_i.tone_len};
    quad = ph[PHASE_BITS-1 -: 2];
    addr = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    if (quad[0]) begin
      addr = ~addr;
    end
    phase_d    = phase_q;
    frame_d    = frame_q;
    s1_valid_d = s1_valid_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
    end
    if (accept) begin
      phase_d = done ? '0 : ph + PHASE_BITS'(cfg_i.phase_inc);
      frame_d = done ? '0 : fi + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      frame_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      frame_q    <= frame_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // registered rom read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rom_q  <= SineRom[addr];
      neg_q  <= quad[1];
      done_q <= done;
    end
  end

  assign entry_valid_o = s1_valid_q;
  assign entry_o.mag   = rom_q;
  assign entry_o.neg   = neg_q;
  assign entry_o.done  = done_q;

endmodule

// File: rtl/core/ste_queue.sv
module ste_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ste_pkg::ste_entry_t wr_entry_i,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  output ste_pkg::ste_entry_t rd_entry_o,
  output logic                rd_valid_o,
  input  logic                rd_ready_i
);
  import ste_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  ste_entry_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push;
  logic                pop;

  assign wr_ready_o = count_q != CntW'(QUEUE_DEPTH);
  assign rd_valid_o = count_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

// File: rtl/core/ste_back.sv
module ste_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ste_pkg::ste_cfg_t   cfg_i,
  input  ste_pkg::ste_entry_t entry_i,
  input  logic                entry_valid_i,
  output logic                entry_ready_o,
  sine_tone_out_if.source     out_o
);
  import ste_pkg::*;

  logic        valid_q, valid_d;
  logic        chan_q, chan_d;
  logic        last_q, last_d;
  logic        done_q, done_d;
  logic [15:0] sample_q, sample_d;

  logic        fire;
  logic        load;
  logic        stereo;
  logic [16:0] v;
  logic [15:0] w;
  logic [31:0] prod;
  logic [16:0] nmag;
  logic [15:0] conv;

  // sample conversion from the queue head
  always_comb begin
    v    = entry_i.neg ? SINE_OFFSET - {1'b0, entry_i.mag}
                       : SINE_OFFSET + {1'b0, entry_i.mag};
    // floor(v * 255 / 131070) == floor((v >> 1) / 257)
    w    = v[16:1];
    prod = w * U8_RECIP;
    nmag = ({1'b0, entry_i.mag} + 17'd1) >> 1;
    if (cfg_i.out_format) begin
      conv = {8'd0, prod[31:24]};
    end else if (entry_i.neg) begin
      conv = 16'(17'd0 - nmag);
    end else if (entry_i.mag == '0) begin
      conv = '0;
    end else begin
      conv = (entry_i.mag - 16'd1) >> 1;
    end
  end

  assign stereo        = cfg_i.chan_count[1];
  assign fire          = valid_q && out_o.ready;
  assign load          = entry_valid_i && (!valid_q || (fire && last_q));
  assign entry_ready_o = load;

  always_comb begin
    valid_d  = valid_q;
    chan_d   = chan_q;
    last_d   = last_q;
    done_d   = done_q;
    sample_d = sample_q;
    priority if (fire && !last_q) begin
      chan_d = 1'b1;
      last_d = 1'b1;
    end else if (load) begin
      valid_d  = 1'b1;
      chan_d   = 1'b0;
      last_d   = !stereo;
      done_d   = entry_i.done;
      sample_d = conv;
    end else if (fire) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      chan_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      chan_q  <= chan_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    done_q   <= done_d;
    sample_q <= sample_d;
  end

  assign out_o.valid         = valid_q;
  assign out_o.sample        = sample_q;
  assign out_o.channel       = chan_q;
  assign out_o.last_in_frame = last_q;
  assign out_o.tone_done     = done_q;

endmodule

// File: rtl/core/sine_tone_generator.sv
// path: an accepted restart beat passes the front rom register, queue and output register
// throughput: one frame per cycle in mono while the output is ready; in stereo the output
//   register sends the second channel beat from the same register before the next frame
// reset: asynchronous active low; config returns to defaults, phase and frame count to zero,
//   pipeline and queue empty; the sine rom is constant, so no clearing pass
module sine_tone_generator #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sine_tone_in_if.sink                      in_i,
  sine_tone_out_if.source                   out_o,
  input  logic                              cfg_we_i,
  input  logic [ste_pkg::STE_CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ste_pkg::STE_CFG_DATA_W-1:0] cfg_data_i
);
  import ste_pkg::*;

  // configuration registers, to be written only while idle; the block does not enforce this
  ste_cfg_t   cfg_q, cfg_d;

  // front to queue and queue to back
  ste_entry_t fr_entry;
  logic       fr_valid;
  logic       fr_ready;
  ste_entry_t bk_entry;
  logic       bk_valid;
  logic       bk_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ste_cfg_idx_e'(cfg_idx_i))
        CFG_PHASE_INC:  cfg_d.phase_inc  = cfg_data_i[30:0];
        CFG_OUT_FORMAT: cfg_d.out_format = cfg_data_i[0];
        CFG_CHAN_COUNT: cfg_d.chan_count = cfg_data_i[1:0];
        CFG_TONE_LEN:   cfg_d.tone_len   = cfg_data_i[31:0];
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_inc  <= PHASE_INC_RESET;
      cfg_q.out_format <= FORMAT_RESET;
      cfg_q.chan_count <= CHAN_CNT_RESET;
      cfg_q.tone_len   <= TONE_LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: phase accumulator, frame counter, tone end detect, rom lookup
  ste_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_i          (in_i),
    .entry_o       (fr_entry),
    .entry_valid_o (fr_valid),
    .entry_ready_i (fr_ready)
  );

  // short queue so the accumulator keeps running while the output stalls
  ste_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_entry_i (fr_entry),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .rd_entry_o (bk_entry),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready)
  );

  // back: sample format conversion and per-channel beats
  ste_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .entry_i       (bk_entry),
    .entry_valid_i (bk_valid),
    .entry_ready_o (bk_ready),
    .out_o         (out_o)
  );

endmodule

// File: rtl/core/ste_chk.sv
`include "sine_tone_generator_macros.svh"

module ste_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] sample_i,
  input logic        channel_i,
  input logic        last_i,
  input logic        done_i
);

  // a stalled beat keeps its payload
  `STE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(sample_i) && $stable(channel_i) && $stable(last_i) && $stable(done_i))

  // the second channel beat follows at once with the same sample
  `STE_ASSERT_NEXT(a_ch1_follows, out_valid_i && out_ready_i && !last_i, out_valid_i && channel_i && last_i && $stable(sample_i) && $stable(done_i))

  // channel one always closes its frame
  `STE_ASSERT_NOW(a_ch1_last, out_valid_i && channel_i, last_i)

  // no beat is offered while reset is held
  `STE_ASSERT_ALWAYS(a_idle_in_reset, rst_ni || !out_valid_i)

endmodule

bind sine_tone_generator ste_chk u_ste_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .sample_i    (out_o.sample),
  .channel_i   (out_o.channel),
  .last_i      (out_o.last_in_frame),
  .done_i      (out_o.tone_done)
);

// File: dv/tb_sine_tone_generator.sv
module tb_sine_tone_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import ste_pkg::*;

  // run limits
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 8;    // slack after every expected beat has arrived
  localparam int unsigned LONG_HOLD    = 200;  // receiver hold-off used once for back-pressure
  localparam int unsigned MAX_REPORTS  = 30;
  localparam logic [3:0]  ALL_REGS     = 4'b1111;

  // Q30 taylor coefficients of sin(pi/2 * t), magnitudes, highest power last
  localparam longint unsigned TAYLOR_Q30 [7] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864, 64'd61
  };

  // one sample beat as the block should present it
  typedef struct packed {
    logic [15:0] sample;
    logic        channel;
    logic        last_in_frame;
    logic        tone_done;
  } tone_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  sine_tone_in_if  in_if ();
  sine_tone_out_if out_if ();

  sine_tone_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state: register copies, oscillator phase and frame count
  logic [15:0] quarter_wave [1024];
  ste_cfg_t    cfg_shadow;
  logic [31:0] nco_phase;
  logic [31:0] frame_cnt;

  // frames waiting to be offered (restart bit each) and beats still owed by the block
  bit          frames_to_send [$];
  tone_beat_t  pending_beats [$];

  // idle shaping, set per phase by the stimulus
  int unsigned tx_max_gap = 0;
  int unsigned rx_max_gap = 0;
  bit          stall_request = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned tx_gap;
  int unsigned rx_wait;

  // bookkeeping
  int unsigned error_count = 0;
  int unsigned frames_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned tones_ended = 0;
  int unsigned settings_applied = 0;
  int unsigned cycle_count = 0;
  tone_beat_t  rx_expected;

  // fill the quarter-wave magnitude rom the same way the block's rom was generated:
  // fixed-point polynomial in Q30, truncating shifts, rounded to 16 bits
  function automatic void build_quarter_wave();
    longint unsigned t, u, r, p, s, e;
    int k, i;
    for (k = 0; k < 1024; k++) begin
      t = 64'(2 * k + 1) << 19;
      u = (t * t) >> 30;
      r = TAYLOR_Q30[6];
      for (i = 5; i >= 0; i--) begin
        p = (r * u) >> 30;
        r = (p >= TAYLOR_Q30[i]) ? 64'd0 : TAYLOR_Q30[i] - p;
      end
      s = (r * t) >> 30;
      e = (s * 64'd65535 + (64'd1 << 29)) >> 30;
      if (e > 64'd65535) e = 64'd65535;
      quarter_wave[k] = e[15:0];
    end
  endfunction

  // sample value for a phase in the current output format
  function automatic logic [15:0] phase_to_sample(logic [31:0] ph, logic fmt);
    logic [1:0]      quad;
    logic [9:0]      addr;
    logic [15:0]     mag16;
    longint unsigned v;
    quad = ph[31:30];
    addr = ph[29:20];
    // odd quadrants run the table backwards
    if (quad[0]) addr = 10'd1023 - addr;
    mag16 = quarter_wave[addr];
    if (fmt) begin
      // unsigned 8-bit keeps the negative half: floor((65535 + s) * 255 / 131070)
      v = quad[1] ? 64'd65535 - mag16 : 64'd65535 + mag16;
      v = (v * 64'd255) / 64'd131070;
      if (v > 64'd255) v = 64'd255;
      return v[15:0];
    end
    if (!quad[1]) begin
      v = (mag16 == 16'd0) ? 64'd0 : (64'(mag16) - 64'd1) >> 1;
      if (v > 64'd32767) v = 64'd32767;
      return v[15:0];
    end
    v = (64'(mag16) + 64'd1) >> 1;
    if (v > 64'd32768) v = 64'd32768;
    v = 64'd65536 - v;
    return v[15:0];
  endfunction

  // one accepted frame: queue its beats and step the oscillator
  function automatic void advance_tone_frame(logic restart);
    tone_beat_t  b;
    logic [15:0] smp;
    logic        done;
    int          n, c;
    if (restart) begin
      nco_phase = '0;
      frame_cnt = '0;
    end
    smp  = phase_to_sample(nco_phase, cfg_shadow.out_format);
    // tone length zero ends every frame, a length below the count ends the next one
    done = (33'(frame_cnt) + 33'd1 >= 33'(cfg_shadow.tone_len));
    // channel count 0 acts as mono, 3 as stereo
    n = (cfg_shadow.chan_count >= 2'd2) ? 2 : 1;
    for (c = 0; c < n; c++) begin
      b.sample        = smp;
      b.channel       = c[0];
      b.last_in_frame = (c == n - 1);
      b.tone_done     = done;
      pending_beats.push_back(b);
    end
    if (done) begin
      nco_phase = '0;
      frame_cnt = '0;
    end else begin
      nco_phase = nco_phase + 32'(cfg_shadow.phase_inc);
      frame_cnt = frame_cnt + 32'd1;
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (error_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // input driver: offer queued frames, random gap after each beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.restart <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        advance_tone_frame(in_if.restart);
        frames_sent++;
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap != 0) begin
          in_if.valid <= 1'b0;
          tx_gap      <= tx_gap - 1;
        end else if (frames_to_send.size() != 0) begin
          in_if.valid   <= 1'b1;
          in_if.restart <= frames_to_send.pop_front();
          tx_gap        <= $urandom_range(0, tx_max_gap);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: check each sample beat against the oldest expectation,
  // drop ready for a random number of cycles after each beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_beats.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("%0t: unexpected sample beat, expected none, actual %0h ch %0b",
                     $time, out_if.sample, out_if.channel);
          error_count++;
        end else begin
          rx_expected = pending_beats.pop_front();
          check_field("sample", rx_expected.sample, out_if.sample);
          check_field("channel", rx_expected.channel, out_if.channel);
          check_field("last_in_frame", rx_expected.last_in_frame, out_if.last_in_frame);
          check_field("tone_done", rx_expected.tone_done, out_if.tone_done);
          if (rx_expected.tone_done && rx_expected.last_in_frame) tones_ended++;
        end
        beats_checked++;
        rx_wait = $urandom_range(0, rx_max_gap);
      end
      // one long hold-off so the block backs up and stalls its input
      if (stall_request && !long_hold_done) begin
        rx_wait = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (rx_wait != 0) begin
        out_if.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, pending_beats.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // wait until the sender is empty and every expected beat has arrived
  task automatic drain();
    do @(negedge clk_i);
    while (frames_to_send.size() != 0 || in_if.valid || pending_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(ste_cfg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_PHASE_INC:  cfg_shadow.phase_inc  = value[30:0];
      CFG_OUT_FORMAT: cfg_shadow.out_format = value[0];
      CFG_CHAN_COUNT: cfg_shadow.chan_count = value[1:0];
      CFG_TONE_LEN:   cfg_shadow.tone_len   = value;
      default: ;
    endcase
  endtask

  // write the registers selected by which, only while the block is idle
  task automatic apply_setting(logic [3:0] which, logic [30:0] inc, logic fmt,
                               logic [1:0] chans, logic [31:0] len);
    if (which[CFG_PHASE_INC])  write_reg(CFG_PHASE_INC, {1'b0, inc});
    if (which[CFG_OUT_FORMAT]) write_reg(CFG_OUT_FORMAT, {31'd0, fmt});
    if (which[CFG_CHAN_COUNT]) write_reg(CFG_CHAN_COUNT, {30'd0, chans});
    if (which[CFG_TONE_LEN])   write_reg(CFG_TONE_LEN, len);
    if (which != 4'b0000) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
    end
    settings_applied++;
  endtask

  // directed frame run: optional restart on the first frame, then plain frames
  task automatic run_frames(bit first_restart, int unsigned count);
    int unsigned j;
    for (j = 0; j < count; j++) frames_to_send.push_back(j == 0 ? first_restart : 1'b0);
    drain();
  endtask

  initial begin
    int unsigned ph, j, n_items;
    logic [30:0] inc;
    logic [31:0] len;
    logic [3:0]  which;

    // reset edge at time zero, after every process is waiting
    rst_ni <= 1'b0;

    // predictor starts from the reset state
    build_quarter_wave();
    cfg_shadow.phase_inc  = PHASE_INC_RESET;
    cfg_shadow.out_format = FORMAT_RESET;
    cfg_shadow.chan_count = CHAN_CNT_RESET;
    cfg_shadow.tone_len   = TONE_LEN_RESET;
    nco_phase = '0;
    frame_cnt = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, no restart
    run_frames(1'b0, 2);

    // quarter-turn steps hit every quadrant and both peaks, then wrap to zero
    apply_setting(ALL_REGS, 31'h4000_0000, 1'b0, 2'd1, 32'hFFFF_FFFF);
    run_frames(1'b1, 5);

    // unsigned 8-bit stereo over the same quadrants
    apply_setting((4'b1 << CFG_OUT_FORMAT) | (4'b1 << CFG_CHAN_COUNT),
                  31'd0, 1'b1, 2'd2, 32'd0);
    run_frames(1'b1, 4);

    // zero increment holds phase, channel count 0 is mono, tone length 0 ends every frame
    apply_setting(ALL_REGS, 31'd0, 1'b0, 2'd0, 32'd0);
    run_frames(1'b0, 3);

    // largest increment, channel count 3 is stereo, three-frame tone
    apply_setting(ALL_REGS, 31'h7FFF_FFFF, 1'b0, 2'd3, 32'd3);
    run_frames(1'b1, 5);

    // shorten the tone below the frame count already reached
    apply_setting((4'b1 << CFG_PHASE_INC) | (4'b1 << CFG_TONE_LEN),
                  31'd1, 1'b0, 2'd0, 32'hFFFF_FFFF);
    run_frames(1'b1, 4);
    apply_setting(4'b1 << CFG_TONE_LEN, 31'd0, 1'b0, 2'd0, 32'd2);
    run_frames(1'b0, 2);

    // random phases: new register setting each time, random frames and idling
    for (ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 4))
        0:       inc = 31'd1;
        1:       inc = 31'h7FFF_FFFF;
        2:       inc = 31'($urandom_range(1, 1 << 20));
        default: inc = 31'($urandom() >> 1);
      endcase
      case ($urandom_range(0, 6))
        0:       len = 32'd0;
        1:       len = 32'd1;
        2:       len = 32'hFFFF_FFFF;
        3:       len = $urandom();
        4:       len = $urandom_range(41, 300);
        default: len = $urandom_range(2, 40);
      endcase
      which = (ph == 0) ? ALL_REGS : 4'($urandom_range(1, 15));
      apply_setting(which, inc, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), len);

      // first phase runs flat out, the pressure phase keeps the sender busy
      if (ph == 0) begin
        tx_max_gap = 0;
        rx_max_gap = 0;
      end else if (ph == 3) begin
        tx_max_gap = 0;
        rx_max_gap = 2;
        stall_request = 1'b1;
      end else begin
        tx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 10;
        rx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 10;
      end

      n_items = $urandom_range(100, 130);
      for (j = 0; j < n_items; j++)
        frames_to_send.push_back($urandom_range(0, 24) == 0);
      drain();
    end

    $display("covered %0d frames and %0d sample beats over %0d register settings",
             frames_sent, beats_checked, settings_applied);
    $display("%0d tones ran to their end, %0d mismatches", tones_ended, error_count);
    if (error_count == 0 && pending_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ste_pkg.sv
rtl/core/sine_tone_generator_if.sv
rtl/core/ste_front.sv
rtl/core/ste_queue.sv
rtl/core/ste_back.sv
rtl/core/sine_tone_generator.sv
rtl/core/ste_chk.sv
dv/tb_sine_tone_generator.sv
